// ===== design/mrfed_pkg.sv =====
// ----------------------------------------------------------------------------
// mrfed_pkg
// Shared types and constants of the Modbus RTU frame end detector.
// ----------------------------------------------------------------------------
package mrfed_pkg;

  // Fixed field widths of the request and response channels
  localparam int BYTE_W  = 8;
  localparam int FUNC_W  = 2;
  localparam int COUNT_W = 9;

  // Request selector codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  // Frame layout: address, function code, length byte, ...
  localparam int FC_POS       = 1;
  localparam int LEN_POS      = 2;
  localparam int LEN_OVERHEAD = 5;
  localparam int MIN_FRAME    = 5;
  localparam int FIXED_LEN    = 8;
  localparam int EXC_BIT      = 7;

  // Function codes whose reply has a fixed length of eight bytes
  localparam logic [BYTE_W-1:0] FC_WRITE_COIL  = 8'd5;
  localparam logic [BYTE_W-1:0] FC_WRITE_REG   = 8'd6;
  localparam logic [BYTE_W-1:0] FC_WRITE_COILS = 8'd15;
  localparam logic [BYTE_W-1:0] FC_WRITE_REGS  = 8'd16;

endpackage

// ===== design/mrfed_req_if.sv =====
// ----------------------------------------------------------------------------
// mrfed_req_if
// Request channel: valid/ready handshake with selector, data byte and index.
// ----------------------------------------------------------------------------
interface mrfed_req_if import mrfed_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] rx_byte;
  logic [BYTE_W-1:0] read_index;

  modport source (output valid, func, rx_byte, read_index, input ready);
  modport sink   (input valid, func, rx_byte, read_index, output ready);
endinterface

// ===== design/mrfed_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mrfed_rsp_if
// Response channel: valid/ready handshake with frame status and read data.
// ----------------------------------------------------------------------------
interface mrfed_rsp_if import mrfed_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               frame_done;
  logic [COUNT_W-1:0] byte_count;
  logic [BYTE_W-1:0]  read_data;

  modport source (output valid, frame_done, byte_count, read_data, input ready);
  modport sink   (input valid, frame_done, byte_count, read_data, output ready);
endinterface

// ===== design/modbus_rtu_frame_end_detector.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_frame_end_detector
// Finds the end of a Modbus RTU response frame in a stream of received bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per handshake: func selects a received byte
//   (rx_byte is stored and counted unless a frame is held), a clear of count and done flag, or a
//   read of the stored byte at read_index. rsp returns exactly one result per
//   request: frame_done and byte_count as they stand after the request, and
//   read_data for a read (zero otherwise or when read_index is beyond the
//   store).
//   A request passes through the engine, where the frame store RAM is
//   written or read, then through stage 1 to the output register it leaves from.
//   One request is accepted every cycle while rsp takes results; the single RAM
//   access per request sets that figure.
//   Reset clears the count, the done flag and both pipeline stages; the
//   frame store keeps whatever it holds and needs no clearing pass.
//   When rsp stalls, the output register and the stage behind it fill and
//   req.ready drops; the RAM read data holds while the stage waits.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_end_detector import mrfed_pkg::*; #(
  parameter int BUF_DEPTH = 256
) (
  input logic         clk,
  input logic         rst,
  mrfed_req_if.sink   req,
  mrfed_rsp_if.source rsp
);

  localparam int CW = $clog2(BUF_DEPTH + 1);

  logic              accept;
  logic [CW-1:0]     count_next;
  logic              done_next;
  logic [BYTE_W-1:0] rd_data;

  // Stage 1: status snapshot waiting on the RAM read
  logic              s1_valid;
  logic [CW-1:0]     s1_count;
  logic              s1_done;
  logic              s1_read;
  logic              s1_advance;

  // Output register
  logic               out_valid;
  logic               out_done;
  logic [COUNT_W-1:0] out_count;
  logic [BYTE_W-1:0]  out_data;

  assign s1_advance = s1_valid && (!out_valid || rsp.ready);
  assign req.ready  = !s1_valid || !out_valid || rsp.ready;
  assign accept     = req.valid && req.ready;

  mrfed_engine #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .func       (req.func),
    .rx_byte    (req.rx_byte),
    .read_index (req.read_index),
    .count_next (count_next),
    .done_next  (done_next),
    .rd_data    (rd_data)
  );

  // Advance stage 1 on acceptance, drop it once it moves to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_count <= count_next;
      s1_done  <= done_next;
      s1_read  <= (req.func == FUNC_READ) && (32'(req.read_index) < BUF_DEPTH);
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_done  <= s1_done;
      out_count <= COUNT_W'(s1_count);
      out_data  <= s1_read ? rd_data : '0;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.frame_done = out_done;
  assign rsp.byte_count = out_count;
  assign rsp.read_data  = out_data;

endmodule

// ===== design/mrfed_ram.sv =====
// ----------------------------------------------------------------------------
// mrfed_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mrfed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/mrfed_engine.sv =====
// ----------------------------------------------------------------------------
// mrfed_engine
// Frame store, byte counter and end-of-frame tests for one request a cycle.
// ----------------------------------------------------------------------------
module mrfed_engine import mrfed_pkg::*; #(
  parameter int BUF_DEPTH = 256,
  localparam int AW       = $clog2(BUF_DEPTH),
  localparam int CW       = $clog2(BUF_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [FUNC_W-1:0] func,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] read_index,
  output logic [CW-1:0]     count_next,
  output logic              done_next,
  output logic [BYTE_W-1:0] rd_data
);

  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [CW-1:0]     count;
  logic              done;
  logic [CW-1:0]     count_inc;
  logic [CMPW-1:0]   inc_ext;
  logic [CMPW-1:0]   len_ext;
  logic [BYTE_W-1:0] fcode;
  logic [BYTE_W-1:0] len_byte;
  logic              fixed_code;
  logic              wr_en;
  logic              rd_en;

  always_comb begin
    count_inc  = count + 1'b1;
    inc_ext    = CMPW'(count_inc);
    len_ext    = CMPW'(len_byte) + CMPW'(LEN_OVERHEAD);
    fixed_code = (fcode == FC_WRITE_COIL) || (fcode == FC_WRITE_REG) ||
                 (fcode == FC_WRITE_COILS) || (fcode == FC_WRITE_REGS);
    count_next = count;
    done_next  = done;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    if (en) begin
      unique case (func)
        FUNC_BYTE: begin
          // Drop bytes once a frame is held
          if (!done) begin
            wr_en      = 1'b1;
            count_next = count_inc;
            if (inc_ext >= CMPW'(MIN_FRAME) && inc_ext == len_ext) begin
              done_next = 1'b1;
            end else if (inc_ext == CMPW'(FIXED_LEN) && fixed_code) begin
              done_next = 1'b1;
            end else if (inc_ext == CMPW'(MIN_FRAME) && fcode[EXC_BIT]) begin
              done_next = 1'b1;
            end else if (32'(count_inc) == BUF_DEPTH) begin
              count_next = '0;
            end
          end
        end
        FUNC_CLEAR: begin
          count_next = '0;
          done_next  = 1'b0;
        end
        FUNC_READ: begin
          rd_en = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= done_next;
    end
  end

  // Shadow copies of the header bytes used by the end tests
  always_ff @(posedge clk) begin
    if (wr_en && count == CW'(FC_POS)) begin
      fcode <= rx_byte;
    end
    if (wr_en && count == CW'(LEN_POS)) begin
      len_byte <= rx_byte;
    end
  end

  mrfed_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (rx_byte),
    .re    (rd_en),
    .raddr (AW'(read_index)),
    .rdata (rd_data)
  );

endmodule

// ===== design/mrfed_checker.sv =====
// ----------------------------------------------------------------------------
// mrfed_checker
// Port-level checks of the frame end detector's response stream.
// ----------------------------------------------------------------------------
module mrfed_checker import mrfed_pkg::*; #(
  parameter int BUF_DEPTH = 256
) (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               frame_done,
  input logic [COUNT_W-1:0] byte_count,
  input logic [BYTE_W-1:0]  read_data
);

  localparam int MAX_FRAME = 255 + LEN_OVERHEAD;

  // An open frame never reaches the store depth
  a_open_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !frame_done) |-> (32'(byte_count) < BUF_DEPTH))
    else $error("open frame count at or beyond store depth");

  // A finished frame has a plausible length
  a_done_len: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && frame_done) |->
      (32'(byte_count) >= MIN_FRAME && 32'(byte_count) <= MAX_FRAME))
    else $error("finished frame with impossible length");

  // Back-to-back finished results describe the same held frame
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && frame_done) ##1 (rsp_valid && rsp_ready && frame_done)
      |-> (byte_count == $past(byte_count)))
    else $error("held frame changed its count");

  // No result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(frame_done) && $stable(byte_count) && $stable(read_data)))
    else $error("stalled result changed");

endmodule

bind modbus_rtu_frame_end_detector mrfed_checker #(
  .BUF_DEPTH (BUF_DEPTH)
) u_mrfed_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .frame_done (rsp.frame_done),
  .byte_count (rsp.byte_count),
  .read_data  (rsp.read_data)
);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Modbus RTU frame end detector: directed frames
// of each kind, then random well-formed replies with reads, clears and noise,
// all checked against a cycle-free model of the frame store and end tests.
// ----------------------------------------------------------------------------
module tb;
  import mrfed_pkg::*;

  localparam int STORE_DEPTH = 256;
  localparam int PIPE_CYCLES = 20;      // well beyond the two-stage latency
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;      // long receiver hold-off
  localparam int PHASE_ITEMS = 360;

  // Selector value the block leaves unused
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef enum int {FR_DATA, FR_FIXED, FR_EXCEPT} frame_kind_t;

  // --------------------------------------------------------------------------
  // Frame status model and store of expected responses
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    typedef struct {
      logic               frame_done;
      logic [COUNT_W-1:0] byte_count;
      logic [BYTE_W-1:0]  read_data;
    } status_t;

    logic [BYTE_W-1:0] store [STORE_DEPTH];
    bit                written [STORE_DEPTH];
    int unsigned       count;
    bit                done;
    status_t           status_q [$];
    int                errors;
    int                frames;
    int                reads;
    int                checked;

    function new();
      count   = 0;
      done    = 0;
      errors  = 0;
      frames  = 0;
      reads   = 0;
      checked = 0;
      foreach (written[k]) written[k] = 0;
    endfunction

    static function bit fixed_reply(logic [BYTE_W-1:0] c);
      return c == FC_WRITE_COIL || c == FC_WRITE_REG ||
             c == FC_WRITE_COILS || c == FC_WRITE_REGS;
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      bit hit;
      logic [BYTE_W-1:0] code;
      hit = 0;
      if (count < STORE_DEPTH) begin
        store[count]   = b;
        written[count] = 1;
      end
      count++;
      if (count >= MIN_FRAME) begin
        code = store[FC_POS];
        if (count == int'(store[LEN_POS]) + LEN_OVERHEAD) hit = 1;
        else if (count == FIXED_LEN && fixed_reply(code)) hit = 1;
        else if (count == MIN_FRAME && code[EXC_BIT]) hit = 1;
      end
      if (hit) begin
        done = 1;
        frames++;
      end else if (count > STORE_DEPTH - 1) begin
        count = 0;
      end
    endfunction

    // Apply one accepted request; returns 0 when the block drops a byte
    function bit note_request(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b,
                              logic [BYTE_W-1:0] idx);
      status_t s;
      bit took;
      took = 1;
      s.read_data = '0;
      case (f)
        FUNC_BYTE: begin
          if (done) took = 0;
          else take_byte(b);
        end
        FUNC_CLEAR: begin
          count = 0;
          done  = 0;
        end
        FUNC_READ: begin
          if (int'(idx) < STORE_DEPTH) s.read_data = store[idx];
          reads++;
        end
        default: ;
      endcase
      s.frame_done = done;
      s.byte_count = count[COUNT_W-1:0];
      status_q.push_back(s);
      return took;
    endfunction

    function void check_result(logic fd, logic [COUNT_W-1:0] cnt,
                               logic [BYTE_W-1:0] data);
      status_t s;
      if (status_q.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      s = status_q.pop_front();
      checked++;
      if (fd !== s.frame_done) begin
        $error("frame_done: expected %0d, got %0d", s.frame_done, fd);
        errors++;
      end
      if (cnt !== s.byte_count) begin
        $error("byte_count: expected %0d, got %0d", s.byte_count, cnt);
        errors++;
      end
      if (data !== s.read_data) begin
        $error("read_data: expected 0x%02h, got 0x%02h", s.read_data, data);
        errors++;
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    // Random index among the written entries, -1 while none is written
    function int pick_read_index();
      int start;
      start = $urandom_range(STORE_DEPTH - 1);
      for (int k = 0; k < STORE_DEPTH; k++)
        if (written[(start + k) % STORE_DEPTH]) return (start + k) % STORE_DEPTH;
      return -1;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  mrfed_req_if req_ch ();
  mrfed_rsp_if rsp_ch ();

  modbus_rtu_frame_end_detector #(.BUF_DEPTH(STORE_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  frame_scoreboard sb;
  int idle_pct   = 0;
  int stall_pct  = 0;
  bit hold_arm   = 0;
  int hold_left  = 0;
  int sent_items = 0;
  int cycles     = 0;

  // Drive known values before the first edge
  initial begin
    req_ch.valid      = 1'b0;
    req_ch.func       = FUNC_BYTE;
    req_ch.rx_byte    = '0;
    req_ch.read_index = '0;
    rsp_ch.ready      = 1'b0;
  end

  // Receiver: stall at random, or hold off for a long stretch when armed.
  // The hold-off is counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (hold_arm) begin
        hold_arm  = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check every response as it is accepted
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_result(rsp_ch.frame_done, rsp_ch.byte_count, rsp_ch.read_data);
  end

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycles, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request drivers
  // --------------------------------------------------------------------------

  // Offer one request, idling first at random; hold it until accepted
  task automatic put_req(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b,
                         logic [BYTE_W-1:0] idx);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= f;
    req_ch.rx_byte    <= b;
    req_ch.read_index <= idx;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    void'(sb.note_request(f, b, idx));
    sent_items++;
  endtask

  task automatic put_byte(logic [BYTE_W-1:0] b);
    put_req(FUNC_BYTE, b, BYTE_W'($urandom_range(255)));
  endtask

  task automatic put_clear();
    put_req(FUNC_CLEAR, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
  endtask

  // Read only entries already written; before that, send a clear instead
  task automatic put_read();
    int idx;
    idx = sb.pick_read_index();
    if (idx < 0) put_clear();
    else put_req(FUNC_READ, BYTE_W'($urandom_range(255)), BYTE_W'(idx));
  endtask

  task automatic put_noise();
    logic [FUNC_W-1:0] f;
    f = FUNC_W'($urandom_range(3));
    if (f == FUNC_READ) put_read();
    else put_req(f, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
  endtask

  // Drop valid and wait until every response has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Send one reply frame of the given kind; long_len sets the length byte
  // of a data frame. A few frames are cut short and cleared mid-way.
  task automatic send_frame(frame_kind_t kind, int long_len = -1);
    logic [BYTE_W-1:0] fc;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] b;
    int n;
    int cut;
    case (kind)
      FR_FIXED: begin
        case ($urandom_range(3))
          0: fc = FC_WRITE_COIL;
          1: fc = FC_WRITE_REG;
          2: fc = FC_WRITE_COILS;
          default: fc = FC_WRITE_REGS;
        endcase
        // small length bytes end the frame early on the length test
        len = ($urandom_range(3) == 0) ? BYTE_W'($urandom_range(3))
                                       : BYTE_W'($urandom_range(255));
        n = FIXED_LEN;
      end
      FR_EXCEPT: begin
        fc  = BYTE_W'($urandom_range(127)) | 8'h80;
        len = BYTE_W'($urandom_range(255));
        n   = MIN_FRAME;
      end
      default: begin
        fc = BYTE_W'($urandom_range(127));
        if (frame_scoreboard::fixed_reply(fc)) fc = 8'h03;
        if (long_len >= 0) len = BYTE_W'(long_len);
        else if ($urandom_range(79) == 0) len = BYTE_W'($urandom_range(251, 255));
        else len = BYTE_W'($urandom_range(24));
        n = (int'(len) + LEN_OVERHEAD > STORE_DEPTH) ? STORE_DEPTH
                                                     : int'(len) + LEN_OVERHEAD;
      end
    endcase
    cut = (long_len < 0 && $urandom_range(6) == 0) ? $urandom_range(1, n - 1) : n;
    for (int k = 0; k < cut; k++) begin
      if (k == FC_POS) b = fc;
      else if (k == LEN_POS) b = len;
      else b = BYTE_W'($urandom_range(255));
      put_byte(b);
    end
    if (cut < n) put_clear();
  endtask

  // One random phase: mostly complete frames followed by trailing bytes,
  // reads and a clear; the rest is noise
  task automatic run_phase(int idle, int stall, int target, bit with_hold,
                           int long_len);
    int r;
    frame_kind_t kind;
    idle_pct  = idle;
    stall_pct = stall;
    target    = sent_items + target;
    if (with_hold) hold_arm = 1;
    if (long_len >= 0) begin
      send_frame(FR_DATA, long_len);
      repeat (4) put_read();
      put_clear();
    end
    while (sent_items < target) begin
      r = $urandom_range(99);
      if (r < 12) begin
        repeat ($urandom_range(1, 4)) put_noise();
      end else begin
        r = $urandom_range(99);
        kind = (r < 60) ? FR_DATA : (r < 80) ? FR_FIXED : FR_EXCEPT;
        send_frame(kind);
        repeat ($urandom_range(2)) put_byte(BYTE_W'($urandom_range(255)));
        repeat ($urandom_range(3)) put_read();
        if ($urandom_range(9) != 0) put_clear();
      end
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [BYTE_W-1:0] early_frame [5];
    logic [BYTE_W-1:0] exc_frame [5];
    logic [BYTE_W-1:0] fixed_frame [8];
    early_frame = '{8'h11, 8'h0F, 8'h00, 8'h00, 8'hFF};
    exc_frame   = '{8'h01, 8'h83, 8'h02, 8'h00, 8'hFF};
    fixed_frame = '{8'h01, 8'h06, 8'h20, 8'h00, 8'h7F, 8'h80, 8'h00, 8'hFF};
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a write-coils reply whose zero length byte ends it at five
    foreach (early_frame[k]) put_byte(early_frame[k]);
    // byte after completion is dropped
    put_byte(8'hA5);
    put_req(FUNC_READ, 8'h00, 8'd1);
    // unused selector changes nothing
    put_req(FUNC_UNUSED, 8'hFF, 8'hFF);
    put_clear();
    // exception reply ends at five bytes
    foreach (exc_frame[k]) put_byte(exc_frame[k]);
    put_clear();
    // write-register reply runs to the fixed length of eight
    foreach (fixed_frame[k]) put_byte(fixed_frame[k]);
    put_req(FUNC_READ, 8'h00, 8'd7);
    put_req(FUNC_READ, 8'hFF, 8'd4);
    put_clear();
    drain();

    // Random phases; the first fills the store with a frame ending at the
    // full count, the third with one that wraps the count back to zero
    run_phase(0, 0, PHASE_ITEMS, 1'b1, STORE_DEPTH - LEN_OVERHEAD);
    run_phase(70, 0, PHASE_ITEMS, 1'b0, -1);
    run_phase(0, 70, PHASE_ITEMS, 1'b0, 255);
    run_phase(16, 16, PHASE_ITEMS, 1'b0, -1);

    // Let any stray response surface before the verdict
    repeat (PIPE_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d responses checked, %0d frames ended, %0d reads",
             sent_items, sb.checked, sb.frames, sb.reads);
    $display("phases: no idling, sender idle, receiver stalling, both; %0d cycles",
             cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
